[hw/rtl/bvpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvpe_pkg
// Shared types and constants for the battery voltage peak/EMA unit.
// ----------------------------------------------------------------------------
package bvpe_pkg;

  localparam int ADC_BITS     = 12;
  localparam int MV_W         = 16;
  localparam int RATIO_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int TDATA_IN_W   = 16;

  // |peak - low| * 1000 fits in 22 bits, as does the tap voltage
  localparam int MAG_W        = ADC_BITS;
  localparam int DIVIDEND_W   = 22;
  localparam int TAP_W        = 22;
  localparam int PROD_W       = TAP_W + RATIO_W;
  localparam int FRAC_BITS    = 12;
  localparam int DIV_STEPS    = DIVIDEND_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int EMA_SUM_W    = MV_W + 3;

  localparam logic [ADC_BITS-1:0]   LOW_DEFAULT   = ADC_BITS'(2469);
  localparam logic [ADC_BITS-1:0]   SPAN_DEFAULT  = ADC_BITS'(2429);
  localparam logic [9:0]            MV_PER_V      = 10'd1000;
  localparam logic [RATIO_W-1:0]    RATIO_RESET   = RATIO_W'(8192);
  localparam logic [MV_W-1:0]       MV_MAX        = '1;
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST      = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_LOW   = 2'd0,
    REG_VOLT_SPAN = 2'd1,
    REG_RATIO     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_TAP,
    ST_MUL,
    ST_EMA,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic load_beat;
    logic prep;
    logic div_step;
    logic tap;
    logic mul;
    logic ema;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic any_good;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/bvpe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvpe_ctrl
// Sequencer: takes beats; at a burst end, steps the datapath through divide,
// scale, filter and result hand-off, or to hand-off alone if no read was good.
// ----------------------------------------------------------------------------
module bvpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  bvpe_pkg::sts_t    sts,
  output bvpe_pkg::cmd_t    cmd
);

  bvpe_pkg::state_t               state;
  bvpe_pkg::state_t               state_next;
  logic [bvpe_pkg::DIV_CNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bvpe_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == bvpe_pkg::ST_PREP) begin
        div_cnt <= '0;
      end else if (state == bvpe_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bvpe_pkg::ST_IDLE: if (s_tvalid && s_tlast) state_next = bvpe_pkg::ST_PREP;
      bvpe_pkg::ST_PREP: state_next = sts.any_good ? bvpe_pkg::ST_DIV : bvpe_pkg::ST_PUT;
      bvpe_pkg::ST_DIV:  if (div_cnt == bvpe_pkg::DIV_LAST) state_next = bvpe_pkg::ST_TAP;
      bvpe_pkg::ST_TAP:  state_next = bvpe_pkg::ST_MUL;
      bvpe_pkg::ST_MUL:  state_next = bvpe_pkg::ST_EMA;
      bvpe_pkg::ST_EMA:  state_next = bvpe_pkg::ST_PUT;
      bvpe_pkg::ST_PUT:  if (sts.out_free) state_next = bvpe_pkg::ST_IDLE;
      default:           state_next = bvpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      bvpe_pkg::ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_beat = s_tvalid;
      end
      bvpe_pkg::ST_PREP: cmd.prep     = 1'b1;
      bvpe_pkg::ST_DIV:  cmd.div_step = 1'b1;
      bvpe_pkg::ST_TAP:  cmd.tap      = 1'b1;
      bvpe_pkg::ST_MUL:  cmd.mul      = 1'b1;
      bvpe_pkg::ST_EMA:  cmd.ema      = 1'b1;
      bvpe_pkg::ST_PUT:  cmd.put      = sts.out_free;
      default: ;
    endcase
  end

endmodule

[hw/rtl/bvpe_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvpe_datapath
// Peak tracking, calibration registers, restoring divider, ratio multiply,
// EMA filter and the output register.
// ----------------------------------------------------------------------------
module bvpe_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bvpe_pkg::cmd_t                    cmd,
  output bvpe_pkg::sts_t                    sts,
  input  logic                              read_ok,
  input  logic [bvpe_pkg::ADC_BITS-1:0]     raw_code,
  input  logic                              cfg_valid,
  input  logic [bvpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvpe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [bvpe_pkg::MV_W-1:0]         out_mv,
  output logic                              out_status
);

  logic [bvpe_pkg::ADC_BITS-1:0]   cal_low;
  logic [bvpe_pkg::ADC_BITS-1:0]   volt_span;
  logic [bvpe_pkg::RATIO_W-1:0]    ratio;
  logic [bvpe_pkg::ADC_BITS-1:0]   peak;
  logic                            any_good;
  logic [bvpe_pkg::MV_W-1:0]       filtered;

  logic                            neg;
  logic [bvpe_pkg::DIVIDEND_W-1:0] quo;
  logic [bvpe_pkg::ADC_BITS-1:0]   rem;
  logic [bvpe_pkg::TAP_W-1:0]      tap;
  logic [bvpe_pkg::MV_W-1:0]       inst;

  logic [bvpe_pkg::ADC_BITS-1:0]   low_eff;
  logic [bvpe_pkg::ADC_BITS-1:0]   span_eff;
  logic [bvpe_pkg::ADC_BITS:0]     diff;
  logic [bvpe_pkg::ADC_BITS:0]     diff_neg;
  logic [bvpe_pkg::MAG_W-1:0]      mag;
  logic [bvpe_pkg::ADC_BITS:0]     rem_sh;
  logic [bvpe_pkg::ADC_BITS:0]     rem_sub;
  logic [bvpe_pkg::DIVIDEND_W:0]   tap_pos;
  logic [bvpe_pkg::DIVIDEND_W:0]   tap_neg;
  logic [bvpe_pkg::PROD_W-1:0]     prod;
  logic [bvpe_pkg::PROD_W-bvpe_pkg::FRAC_BITS-1:0] scaled;
  logic [bvpe_pkg::EMA_SUM_W-1:0]  ema_sum;

  assign low_eff  = (cal_low   == '0) ? bvpe_pkg::LOW_DEFAULT  : cal_low;
  assign span_eff = (volt_span == '0) ? bvpe_pkg::SPAN_DEFAULT : volt_span;

  assign diff     = {1'b0, peak} - {1'b0, low_eff};
  assign diff_neg = -diff;
  assign mag      = diff[bvpe_pkg::ADC_BITS] ? diff_neg[bvpe_pkg::MAG_W-1:0]
                                             : diff[bvpe_pkg::MAG_W-1:0];

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem, quo[bvpe_pkg::DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, span_eff};

  // signed add of +/-quotient to 1000, clamped at zero
  assign tap_pos = {1'b0, quo} + (bvpe_pkg::DIVIDEND_W+1)'(bvpe_pkg::MV_PER_V);
  assign tap_neg = (bvpe_pkg::DIVIDEND_W+1)'(bvpe_pkg::MV_PER_V) - {1'b0, quo};

  assign prod   = (bvpe_pkg::PROD_W)'(tap) * (bvpe_pkg::PROD_W)'(ratio);
  assign scaled = prod[bvpe_pkg::PROD_W-1:bvpe_pkg::FRAC_BITS];

  assign ema_sum = {filtered, 3'b000} - {3'b000, filtered} + {3'b000, inst};

  assign sts.any_good = any_good;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low   <= '0;
      volt_span <= '0;
      ratio     <= bvpe_pkg::RATIO_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bvpe_pkg::REG_CAL_LOW:   cal_low   <= cfg_data[bvpe_pkg::ADC_BITS-1:0];
        bvpe_pkg::REG_VOLT_SPAN: volt_span <= cfg_data[bvpe_pkg::ADC_BITS-1:0];
        bvpe_pkg::REG_RATIO:     ratio     <= cfg_data[bvpe_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      any_good  <= 1'b0;
      filtered  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_beat && read_ok) begin
        any_good <= 1'b1;
        if (raw_code > peak) peak <= raw_code;
      end
      if (cmd.ema) begin
        filtered <= (filtered == '0) ? inst : ema_sum[bvpe_pkg::EMA_SUM_W-1:3];
      end
      if (cmd.put) begin
        out_valid <= 1'b1;
        peak      <= '0;
        any_good  <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg <= diff[bvpe_pkg::ADC_BITS];
      quo <= (bvpe_pkg::DIVIDEND_W)'(mag) * (bvpe_pkg::DIVIDEND_W)'(bvpe_pkg::MV_PER_V);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[bvpe_pkg::ADC_BITS]) begin
        rem <= rem_sub[bvpe_pkg::ADC_BITS-1:0];
        quo <= {quo[bvpe_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[bvpe_pkg::ADC_BITS-1:0];
        quo <= {quo[bvpe_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
    if (cmd.tap) begin
      if (!neg) begin
        tap <= tap_pos[bvpe_pkg::TAP_W-1:0];
      end else if (tap_neg[bvpe_pkg::DIVIDEND_W]) begin
        tap <= '0;
      end else begin
        tap <= tap_neg[bvpe_pkg::TAP_W-1:0];
      end
    end
    if (cmd.mul) begin
      inst <= (scaled > {{($bits(scaled)-bvpe_pkg::MV_W){1'b0}}, bvpe_pkg::MV_MAX})
              ? bvpe_pkg::MV_MAX : scaled[bvpe_pkg::MV_W-1:0];
    end
    if (cmd.put) begin
      out_mv     <= any_good ? filtered : '0;
      out_status <= !any_good;
    end
  end

endmodule

[hw/rtl/battery_voltage_peak_ema_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_peak_ema_unit
// Peak of the good ADC reads in a burst, converted to mV and EMA filtered.
// ----------------------------------------------------------------------------
// Beats that do not end a burst are accepted while the unit is idle.
// A burst end with good reads runs prep, the 22-step restoring divide by span,
// tap, multiply and EMA before its result; an empty burst skips to the output.
// The next burst is taken once the result is in the output register.
// Synchronous reset clears state and the filter (unseeded); calibration resets.
module battery_voltage_peak_ema_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // [11:0] raw_code, [15:12] zero
  input  logic        s_tuser,     // [0] read_ok
  input  logic        s_tlast,     // last_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // [15:0] voltage_mv
  output logic        m_tuser,     // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bvpe_pkg::cmd_t cmd;
  bvpe_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bvpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bvpe_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .read_ok    (s_tuser),
    .raw_code   (s_tdata[bvpe_pkg::ADC_BITS-1:0]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_mv     (m_tdata),
    .out_status (m_tuser)
  );

endmodule

[hw/rtl/bvpe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvpe_checker
// Port-level checks on the battery voltage peak/EMA unit.
// ----------------------------------------------------------------------------
module bvpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'd0)
    else $error("error result carries nonzero voltage");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_mid_burst: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after a mid-burst beat");

  a_end_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken while a burst end is being processed");

endmodule

bind battery_voltage_peak_ema_unit bvpe_checker u_bvpe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
